>>> src/swrt_pkg.sv
// Shared codes and field widths for the window region table.
`default_nettype none
package swrt_pkg;

  // Operation kinds carried in the request.
  localparam logic [2:0] KIND_MAP    = 3'd0;
  localparam logic [2:0] KIND_UNMAP  = 3'd1;
  localparam logic [2:0] KIND_DRAIN  = 3'd2;
  localparam logic [2:0] KIND_PROBE  = 3'd3;
  localparam logic [2:0] KIND_ACCESS = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_SYNTH   = 3'd1;
  localparam logic [2:0] ST_OOB         = 3'd2;
  localparam logic [2:0] ST_TOO_BIG     = 3'd3;
  localparam logic [2:0] ST_NO_SPACE    = 3'd4;
  localparam logic [2:0] ST_WRONG_OWNER = 3'd5;
  localparam logic [2:0] ST_STALE       = 3'd6;

  // Fixed field widths.
  localparam int TAG_W  = 16;
  localparam int HDL_W  = 31;
  localparam int SIZE_W = 23;
  localparam int LEN_W  = 32;

  // Shared adder result: carry out and 64-bit sum.
  typedef struct packed {
    logic        carry;
    logic [63:0] sum;
  } alu_res_t;

endpackage
`default_nettype wire

>>> src/swrt_if.sv
// Request and response channel interfaces of the window region table.
`default_nettype none
interface swrt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] owner_tag;
  logic [30:0] handle;
  logic [63:0] file_offset;
  logic [22:0] region_size;
  logic [63:0] address;
  logic [31:0] length;
  logic        is_write;

  modport source (output valid, kind, owner_tag, handle, file_offset, region_size,
                  address, length, is_write, input ready);
  modport sink   (input valid, kind, owner_tag, handle, file_offset, region_size,
                  address, length, is_write, output ready);
endinterface

interface swrt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] mapped_address;
  logic [3:0]  slot_index;
  logic [30:0] target_handle;
  logic [63:0] file_position;
  logic [4:0]  released_count;
  logic        write_access;

  modport source (output valid, status, mapped_address, slot_index, target_handle,
                  file_position, released_count, write_access, input ready);
  modport sink   (input valid, status, mapped_address, slot_index, target_handle,
                  file_position, released_count, write_access, output ready);
endinterface
`default_nettype wire

>>> src/synthetic_window_region_table_core.sv
// Top level of the window region table: sequencer, used marks and result register.
`default_nettype none
// The block keeps SLOT_COUNT slots of 2^STRIDE_LOG2 bytes each inside an address
// window that starts at the window_base register, and answers map, unmap, drain,
// probe and access requests with one response each. The block takes one request
// at a time: req.ready is high only while the sequencer is idle, and a finished
// response waits in its own output register so the next request can be taken
// before the response transfer. One shared 64-bit adder does every address step
// (window offset, slot start, file position) in turn, and a slot counter walks
// the used marks or the slot payload memory one slot per cycle. After loading a
// response the sequencer returns to idle before the next request is taken. Used
// marks clear at reset; slot payload is only used for used slots and needs no
// clearing.
module synthetic_window_region_table_core
  import swrt_pkg::*;
#(
  parameter int SLOT_COUNT  = 16,
  parameter int STRIDE_LOG2 = 22,
  parameter int OWNER_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata,
  swrt_req_if.sink         req,
  swrt_rsp_if.source       rsp
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int OWN_W = (OWNER_BITS < TAG_W) ? OWNER_BITS : TAG_W;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(SLOT_COUNT - 1);
  localparam logic [63:0]      SLOT_LIMIT = 64'(SLOT_COUNT);
  localparam logic [32:0]      STRIDE_V   = 33'd1 << STRIDE_LOG2;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_MAP  = 4'd2;
  localparam logic [3:0] S_MADD = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_EVAL = 4'd5;
  localparam logic [3:0] S_FPOS = 4'd6;
  localparam logic [3:0] S_DRN  = 4'd7;
  localparam logic [3:0] S_DRNE = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state;

  logic [63:0] window_base;

  // Latched request fields.
  logic [2:0]        op_kind;
  logic [OWN_W-1:0]  op_owner;
  logic [HDL_W-1:0]  op_handle;
  logic [63:0]       op_foff;
  logic [SIZE_W-1:0] op_size;
  logic [63:0]       op_addr;
  logic [LEN_W-1:0]  op_len;
  logic              op_wr;

  // Working registers.
  logic [63:0]      rel;
  logic             no_borrow;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] cmp_slot;
  logic             cmp_en;
  logic [SLOT_COUNT-1:0] used;

  // Result being built.
  logic [2:0]       res_status;
  logic [63:0]      res_maddr;
  logic [3:0]       res_sidx;
  logic [HDL_W-1:0] res_thandle;
  logic [63:0]      res_fpos;
  logic [CNT_W-1:0] res_released;
  logic             res_wacc;

  // Slot store and shared adder.
  logic [OWN_W-1:0]  rd_owner;
  logic [HDL_W-1:0]  rd_handle;
  logic [63:0]       rd_foff;
  logic [SIZE_W-1:0] rd_size;
  logic [IDX_W-1:0]  raddr;
  logic              store_we;
  logic [63:0]       alu_a;
  logic [63:0]       alu_b;
  logic              alu_sub;
  alu_res_t          alu_res;

  // Decode of the window offset.
  logic [IDX_W-1:0]       rel_idx;
  logic [STRIDE_LOG2-1:0] rel_off;
  logic                   in_window;
  logic                   oob;
  logic                   out_free;

  assign rel_idx   = rel[STRIDE_LOG2 +: IDX_W];
  assign rel_off   = rel[STRIDE_LOG2-1:0];
  assign in_window = no_borrow && ((rel >> STRIDE_LOG2) < SLOT_LIMIT);
  // Offset plus length beyond size covers both bounds failures.
  assign oob      = (34'(rel_off) + 34'(op_len)) > 34'(rd_size);
  assign out_free = !rsp.valid || rsp.ready;

  assign req.ready = (state == S_IDLE);
  assign store_we  = (state == S_MAP) && !used[cnt];
  assign raddr     = (state == S_DRN) ? cnt : rel_idx;

  // Steer the shared adder by step.
  always_comb begin
    alu_a   = op_addr;
    alu_b   = window_base;
    alu_sub = 1'b1;
    unique case (state)
      S_MADD: begin
        alu_a   = window_base;
        alu_b   = 64'(cnt) << STRIDE_LOG2;
        alu_sub = 1'b0;
      end
      S_FPOS: begin
        alu_a   = rd_foff;
        alu_b   = 64'(rel_off);
        alu_sub = 1'b0;
      end
      default: begin
        alu_a   = op_addr;
        alu_b   = window_base;
        alu_sub = 1'b1;
      end
    endcase
  end

  swrt_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  swrt_slot_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .OWN_W      (OWN_W),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk       (clk),
    .we        (store_we),
    .waddr     (cnt),
    .wr_owner  (op_owner),
    .wr_handle (op_handle),
    .wr_foff   (op_foff),
    .wr_size   (op_size),
    .raddr     (raddr),
    .rd_owner  (rd_owner),
    .rd_handle (rd_handle),
    .rd_foff   (rd_foff),
    .rd_size   (rd_size)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= 64'd0;
    end else if (cfg_we) begin
      window_base <= cfg_wdata;
    end
  end

  // Latch the request on its transfer.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_kind   <= req.kind;
      op_owner  <= req.owner_tag[OWN_W-1:0];
      op_handle <= req.handle;
      op_foff   <= req.file_offset;
      op_size   <= req.region_size;
      op_addr   <= req.address;
      op_len    <= req.length;
      op_wr     <= req.is_write;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      used   <= '0;
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= (state == S_DRN);
      unique case (state) inside
        S_IDLE: begin
          if (req.valid) begin
            state <= S_DISP;
          end
        end
        S_DISP: begin
          // Clear the result and take the window offset in the same step.
          res_status   <= ST_NOT_SYNTH;
          res_maddr    <= 64'd0;
          res_sidx     <= 4'd0;
          res_thandle  <= '0;
          res_fpos     <= 64'd0;
          res_released <= '0;
          res_wacc     <= 1'b0;
          rel          <= alu_res.sum;
          no_borrow    <= alu_res.carry;
          cnt          <= '0;
          case (op_kind) inside
            KIND_MAP: begin
              if (33'(op_size) > STRIDE_V) begin
                res_status <= ST_TOO_BIG;
                state      <= S_FIN;
              end else begin
                state <= S_MAP;
              end
            end
            KIND_UNMAP, KIND_PROBE, KIND_ACCESS: begin
              state <= S_CHK;
            end
            KIND_DRAIN: begin
              res_status <= ST_OK;
              state      <= S_DRN;
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_MAP: begin
          // Walk the used marks; take the first free slot.
          if (!used[cnt]) begin
            used[cnt]  <= 1'b1;
            res_sidx   <= 4'(cnt);
            res_status <= ST_OK;
            state      <= S_MADD;
          end else if (cnt == LAST_SLOT) begin
            res_status <= ST_NO_SPACE;
            state      <= S_FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MADD: begin
          res_maddr <= alu_res.sum;
          state     <= S_FIN;
        end
        S_CHK: begin
          state <= S_FIN;
          if (in_window) begin
            case (op_kind)
              KIND_PROBE: begin
                if (used[rel_idx]) begin
                  res_status <= ST_OK;
                  res_sidx   <= 4'(rel_idx);
                end
              end
              KIND_UNMAP: begin
                if (used[rel_idx] && (rel_off == '0)) begin
                  res_sidx <= 4'(rel_idx);
                  state    <= S_EVAL;
                end else begin
                  res_status <= ST_STALE;
                end
              end
              default: begin
                if (used[rel_idx]) begin
                  res_sidx <= 4'(rel_idx);
                  state    <= S_EVAL;
                end
              end
            endcase
          end
        end
        S_EVAL: begin
          // Slot payload is now out of the store.
          state <= S_FIN;
          if (op_kind == KIND_UNMAP) begin
            if (rd_owner != op_owner) begin
              res_status <= ST_WRONG_OWNER;
            end else begin
              used[rel_idx] <= 1'b0;
              res_status    <= ST_OK;
            end
          end else if (oob) begin
            res_status <= ST_OOB;
          end else begin
            res_status  <= ST_OK;
            res_thandle <= rd_handle;
            res_wacc    <= op_wr;
            state       <= S_FPOS;
          end
        end
        S_FPOS: begin
          res_fpos <= alu_res.sum;
          state    <= S_FIN;
        end
        S_DRN, S_DRNE: begin
          // Read slot cnt while comparing the slot read in the previous cycle.
          if (state == S_DRN) begin
            cmp_slot <= cnt;
            if (cnt == LAST_SLOT) begin
              state <= S_DRNE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end else begin
            state <= S_FIN;
          end
          if (cmp_en && used[cmp_slot] && (rd_owner == op_owner)) begin
            used[cmp_slot] <= 1'b0;
            res_released   <= res_released + 1'b1;
          end
        end
        S_FIN: begin
          // Hold until the output register is free.
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      rsp.status         <= res_status;
      rsp.mapped_address <= res_maddr;
      rsp.slot_index     <= res_sidx;
      rsp.target_handle  <= res_thandle;
      rsp.file_position  <= res_fpos;
      rsp.released_count <= 5'(res_released);
      rsp.write_access   <= res_wacc;
    end
  end

endmodule
`default_nettype wire

>>> src/swrt_alu.sv
// Shared 64-bit adder/subtractor used by the address steps of the sequencer.
`default_nettype none
module swrt_alu
  import swrt_pkg::*;
(
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire logic        sub,
  output alu_res_t         res
);

  logic [64:0] total;

  // Subtract as a plus inverted b plus one; carry out means no borrow.
  assign total = {1'b0, a} + {1'b0, b ^ {64{sub}}} + {64'd0, sub};
  assign res.carry = total[64];
  assign res.sum   = total[63:0];

endmodule
`default_nettype wire

>>> src/swrt_slot_store.sv
// Slot payload memories: owner, handle, file offset and size, one write and one read port.
`default_nettype none
module swrt_slot_store
  import swrt_pkg::*;
#(
  parameter int SLOT_COUNT = 16,
  parameter int OWN_W      = 16,
  parameter int IDX_W      = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [IDX_W-1:0]  waddr,
  input  wire logic [OWN_W-1:0]  wr_owner,
  input  wire logic [HDL_W-1:0]  wr_handle,
  input  wire logic [63:0]       wr_foff,
  input  wire logic [SIZE_W-1:0] wr_size,
  input  wire logic [IDX_W-1:0]  raddr,
  output logic      [OWN_W-1:0]  rd_owner,
  output logic      [HDL_W-1:0]  rd_handle,
  output logic      [63:0]       rd_foff,
  output logic      [SIZE_W-1:0] rd_size
);

  logic [OWN_W-1:0]  mem_owner  [SLOT_COUNT];
  logic [HDL_W-1:0]  mem_handle [SLOT_COUNT];
  logic [63:0]       mem_foff   [SLOT_COUNT];
  logic [SIZE_W-1:0] mem_size   [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_owner[waddr]  <= wr_owner;
      mem_handle[waddr] <= wr_handle;
      mem_foff[waddr]   <= wr_foff;
      mem_size[waddr]   <= wr_size;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rd_owner  <= mem_owner[raddr];
    rd_handle <= mem_handle[raddr];
    rd_foff   <= mem_foff[raddr];
    rd_size   <= mem_size[raddr];
  end

endmodule
`default_nettype wire

>>> tb/swrt_checker.sv
// Checker for the window region table: watches both channels and predicts every response.
`timescale 1ns / 1ps
module swrt_checker
  import swrt_pkg::*;
#(
  parameter int SLOT_COUNT  = 16,
  parameter int STRIDE_LOG2 = 22,
  parameter int OWNER_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  swrt_req_if         req,
  swrt_rsp_if         rsp,
  output int          fail_count,
  output int          expected_left
);

  localparam logic [63:0] STRIDE = 64'd1 << STRIDE_LOG2;
  localparam logic [63:0] SPAN   = 64'(SLOT_COUNT) * STRIDE;
  localparam logic [15:0] OWNER_MASK =
    (OWNER_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << OWNER_BITS) - 1);

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] mapped_address;
    logic [3:0]  slot_index;
    logic [30:0] target_handle;
    logic [63:0] file_position;
    logic [4:0]  released_count;
    logic        write_access;
  } region_rsp_t;

  logic [63:0] base_q;
  logic        used_q   [SLOT_COUNT];
  logic [15:0] owner_q  [SLOT_COUNT];
  logic [30:0] handle_q [SLOT_COUNT];
  logic [63:0] offset_q [SLOT_COUNT];
  logic [22:0] size_q   [SLOT_COUNT];

  region_rsp_t pending_responses[$];

  // Slot covering an address, or -1 outside the window.
  function automatic int slot_of(logic [63:0] addr);
    logic [63:0] rel;
    if (addr < base_q) return -1;
    rel = addr - base_q;
    if (rel >= SPAN) return -1;
    return int'(rel >> STRIDE_LOG2);
  endfunction

  // Apply one operation to the slot table and return its response.
  function automatic region_rsp_t apply_region_op(logic [2:0] kind, logic [15:0] owner,
                                                  logic [30:0] hdl, logic [63:0] foff,
                                                  logic [22:0] rsize, logic [63:0] addr,
                                                  logic [31:0] len, logic wr);
    region_rsp_t r;
    int          s;
    bit          found;
    logic [15:0] tag;
    logic [63:0] start, off, sz;
    r        = '0;
    r.status = ST_NOT_SYNTH;
    tag      = owner & OWNER_MASK;
    found    = 1'b0;
    case (kind)
      KIND_MAP: begin
        if (64'(rsize) > STRIDE) begin
          r.status = ST_TOO_BIG;
        end else begin
          r.status = ST_NO_SPACE;
          for (s = 0; s < SLOT_COUNT; s++) begin
            if (!found && !used_q[s]) begin
              found            = 1'b1;
              used_q[s]        = 1'b1;
              owner_q[s]       = tag;
              handle_q[s]      = hdl;
              offset_q[s]      = foff;
              size_q[s]        = rsize;
              r.mapped_address = base_q + 64'(s) * STRIDE;
              r.slot_index     = 4'(s);
              r.status         = ST_OK;
            end
          end
        end
      end
      KIND_UNMAP: begin
        s = slot_of(addr);
        if (s >= 0) begin
          if (used_q[s] && base_q + 64'(s) * STRIDE == addr) begin
            r.slot_index = 4'(s);
            if (owner_q[s] != tag) begin
              r.status = ST_WRONG_OWNER;
            end else begin
              used_q[s]  = 1'b0;
              owner_q[s] = '0;
              r.status   = ST_OK;
            end
          end else begin
            r.status = ST_STALE;
          end
        end
      end
      KIND_DRAIN: begin
        for (s = 0; s < SLOT_COUNT; s++) begin
          if (used_q[s] && owner_q[s] == tag) begin
            used_q[s]        = 1'b0;
            owner_q[s]       = '0;
            r.released_count = r.released_count + 5'd1;
          end
        end
        r.status = ST_OK;
      end
      KIND_PROBE: begin
        s = slot_of(addr);
        if (s >= 0 && used_q[s]) begin
          r.status     = ST_OK;
          r.slot_index = 4'(s);
        end
      end
      KIND_ACCESS: begin
        s = slot_of(addr);
        if (s >= 0 && used_q[s]) begin
          start        = base_q + 64'(s) * STRIDE;
          off          = addr - start;
          sz           = 64'(size_q[s]);
          r.slot_index = 4'(s);
          if (off > sz || 64'(len) > sz - off) begin
            r.status = ST_OOB;
          end else begin
            r.status        = ST_OK;
            r.target_handle = handle_q[s];
            r.file_position = offset_q[s] + off;
            r.write_access  = wr;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    region_rsp_t want;
    int          i;
    if (rst) begin
      base_q = '0;
      for (i = 0; i < SLOT_COUNT; i++) used_q[i] = 1'b0;
      pending_responses.delete();
    end else begin
      if (cfg_we) base_q = cfg_wdata;
      if (req.valid && req.ready)
        pending_responses.push_back(apply_region_op(req.kind, req.owner_tag, req.handle,
                                                    req.file_offset, req.region_size,
                                                    req.address, req.length, req.is_write));
      if (rsp.valid && rsp.ready) begin
        if (pending_responses.size() == 0) begin
          $error("response transfer with no request outstanding");
          fail_count++;
        end else begin
          want = pending_responses.pop_front();
          check_field("status",         64'(want.status),         64'(rsp.status));
          check_field("mapped_address", want.mapped_address,      rsp.mapped_address);
          check_field("slot_index",     64'(want.slot_index),     64'(rsp.slot_index));
          check_field("target_handle",  64'(want.target_handle),  64'(rsp.target_handle));
          check_field("file_position",  want.file_position,       rsp.file_position);
          check_field("released_count", 64'(want.released_count), 64'(rsp.released_count));
          check_field("write_access",   64'(want.write_access),   64'(rsp.write_access));
        end
      end
    end
    expected_left <= pending_responses.size();
  end

endmodule

>>> tb/tb_top.sv
// Top of the window region table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import swrt_pkg::*;

  localparam int SLOT_COUNT  = 16;
  localparam int STRIDE_LOG2 = 22;
  localparam int OWNER_BITS  = 16;

  localparam logic [63:0] STRIDE = 64'd1 << STRIDE_LOG2;
  localparam logic [63:0] SPAN   = 64'(SLOT_COUNT) * STRIDE;

  // Random items per window setting; seven settings plus the directed part
  // come to roughly 1550 requests.
  localparam int ITEMS_PER_PHASE = 218;
  localparam int PHASES          = 7;

  // Cycles without any transfer before the run is declared hung. The limit
  // leaves a wide margin over the slowest request (a drain), the sender and
  // receiver idle gaps at 64 percent and the one long receiver hold-off.
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  // Owners that requests mostly come from, so unmap and drain find matches.
  localparam logic [15:0] OWNER_SET [4] = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'h8001};

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [63:0] cfg_wdata;

  swrt_req_if req ();
  swrt_rsp_if rsp ();

  int          fail_count;
  int          expected_left;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          drain_pct;
  int          owner_pool_n;
  bit          hold_req;
  logic [63:0] base_now;
  int          quiet_cycles;

  synthetic_window_region_table_core #(
    .SLOT_COUNT (SLOT_COUNT),
    .STRIDE_LOG2(STRIDE_LOG2),
    .OWNER_BITS (OWNER_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req),
    .rsp      (rsp)
  );

  swrt_checker #(
    .SLOT_COUNT (SLOT_COUNT),
    .STRIDE_LOG2(STRIDE_LOG2),
    .OWNER_BITS (OWNER_BITS)
  ) chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req          (req),
    .rsp          (rsp),
    .fail_count   (fail_count),
    .expected_left(expected_left)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: accept responses at the current idle rate. On the first hold
  // request, drop ready for a long stretch so the block fills up and stalls
  // its request side while the sender keeps offering.
  initial begin
    int hold_left;
    bit hold_done;
    rsp.ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, with random idle cycles in front of it, and hold it
  // until the transfer edge. Returns at that edge.
  task automatic send_op(logic [2:0] kind, logic [15:0] owner, logic [30:0] hdl,
                         logic [63:0] foff, logic [22:0] rsize, logic [63:0] addr,
                         logic [31:0] len, logic wr);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.kind        <= kind;
    req.owner_tag   <= owner;
    req.handle      <= hdl;
    req.file_offset <= foff;
    req.region_size <= rsize;
    req.address     <= addr;
    req.length      <= len;
    req.is_write    <= wr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Move the window only while the block is idle: drain all outstanding
  // responses, let the sequencer settle, then write the base register.
  task automatic set_window(logic [63:0] value);
    req.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    base_now = value;
  endtask

  // Sizes that maps request and that accesses aim at, so that accesses land
  // right on the edge of a mapped region often.
  function automatic logic [63:0] pick_size_hint();
    logic [63:0] h;
    case ($urandom_range(7))
      0:       h = 64'd0;
      1:       h = 64'd1;
      2:       h = 64'd64;
      3:       h = 64'd4096;
      4, 5:    h = STRIDE;
      6:       h = 64'($urandom_range(4095));
      default: h = 64'($urandom_range(32'(STRIDE)));
    endcase
    return h;
  endfunction

  function automatic logic [15:0] pick_owner();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return OWNER_SET[$urandom_range(owner_pool_n - 1)];
  endfunction

  // One random request: mostly addresses inside live-looking slots, some
  // just outside the window, some anywhere.
  task automatic random_op();
    int          pick;
    int          s;
    logic [2:0]  kind;
    logic [63:0] hint, off, addr, foff;
    logic [31:0] len;
    logic [22:0] rsize;
    pick = $urandom_range(99);
    if (pick < 35)                  kind = KIND_MAP;
    else if (pick < 35 + drain_pct) kind = KIND_DRAIN;
    else if (pick < 52)             kind = KIND_UNMAP;
    else if (pick < 67)             kind = KIND_PROBE;
    else if (pick < 96)             kind = KIND_ACCESS;
    else                            kind = 3'($urandom_range(7, 5));
    hint = pick_size_hint();
    case ($urandom_range(3))
      0:       off = 64'd0;
      1:       off = hint & (STRIDE - 1);
      2:       off = (hint - 64'($urandom_range(1))) & (STRIDE - 1);
      default: off = 64'($urandom) & (STRIDE - 1);
    endcase
    // Unmap only succeeds at a slot start, so aim there most of the time.
    if (kind == KIND_UNMAP && $urandom_range(9) < 7) off = 64'd0;
    s = $urandom_range(SLOT_COUNT - 1);
    case ($urandom_range(19))
      0, 1:    addr = {$urandom, $urandom};
      2:       addr = base_now - 64'($urandom_range(3, 1));
      3:       addr = base_now + SPAN - 64'd1 + 64'($urandom_range(1));
      default: addr = base_now + 64'(s) * STRIDE + off;
    endcase
    case ($urandom_range(4))
      0:       len = 32'd0;
      1:       len = 32'(hint - off);
      2:       len = 32'(hint - off + 64'd1);
      3:       len = 32'($urandom_range(64));
      default: len = $urandom;
    endcase
    case ($urandom_range(19))
      0, 1:    rsize = 23'(STRIDE + 64'd1 + 64'($urandom_range(3)));
      2:       rsize = 23'($urandom);
      default: rsize = 23'(hint);
    endcase
    foff = ($urandom_range(9) == 0) ? '1 : {$urandom, $urandom};
    send_op(kind, pick_owner(), 31'($urandom), foff, rsize, addr, len,
            1'($urandom_range(1)));
  endtask

  initial begin
    logic [63:0] phase_base;
    int          k;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    req.valid       = 1'b0;
    req.kind        = KIND_MAP;
    req.owner_tag   = '0;
    req.handle      = '0;
    req.file_offset = '0;
    req.region_size = '0;
    req.address     = '0;
    req.length      = '0;
    req.is_write    = 1'b0;
    hold_req        = 1'b0;
    base_now        = '0;
    tx_idle_pct     = 20;
    rx_idle_pct     = 64;
    drain_pct       = 4;
    owner_pool_n    = 4;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, window at address zero.
    set_window(64'd0);
    // Empty region in slot 0, full-stride region in slot 1 with the largest
    // file offset so the file position wraps.
    send_op(KIND_MAP, 16'h0000, 31'd0, 64'd0, 23'd0, 64'd0, 32'd0, 1'b0);
    send_op(KIND_MAP, 16'hFFFF, 31'h7FFF_FFFF, '1, 23'(STRIDE), 64'd0, 32'd0, 1'b0);
    // Too large, just over a stride and at the top of the field.
    send_op(KIND_MAP, 16'h0001, 31'd5, 64'h10, 23'(STRIDE + 1), 64'd0, 32'd0, 1'b0);
    send_op(KIND_MAP, 16'h0001, 31'd5, 64'h10, 23'h7F_FFFF, 64'd0, 32'd0, 1'b0);
    // Accesses inside, at the edge of and past the end of slot 1.
    send_op(KIND_ACCESS, 16'h0, 31'd0, 64'd0, 23'd0, STRIDE + 1, 32'd1, 1'b1);
    send_op(KIND_ACCESS, 16'h0, 31'd0, 64'd0, 23'd0, 2 * STRIDE - 1, 32'd1, 1'b0);
    send_op(KIND_ACCESS, 16'h0, 31'd0, 64'd0, 23'd0, 2 * STRIDE - 1, 32'd2, 1'b1);
    send_op(KIND_ACCESS, 16'h0, 31'd0, 64'd0, 23'd0, STRIDE, 32'hFFFF_FFFF, 1'b1);
    // Zero-length access at the end of an empty region, then one byte past.
    send_op(KIND_ACCESS, 16'h0, 31'd0, 64'd0, 23'd0, 64'd0, 32'd0, 1'b1);
    send_op(KIND_ACCESS, 16'h0, 31'd0, 64'd0, 23'd0, 64'd0, 32'd1, 1'b0);
    // Access to a free slot and just past the window.
    send_op(KIND_ACCESS, 16'h0, 31'd0, 64'd0, 23'd0, 5 * STRIDE, 32'd4, 1'b1);
    send_op(KIND_ACCESS, 16'h0, 31'd0, 64'd0, 23'd0, SPAN, 32'd0, 1'b0);
    send_op(KIND_PROBE, 16'h0, 31'd0, 64'd0, 23'd0, STRIDE + 123, 32'd0, 1'b0);
    send_op(KIND_PROBE, 16'h0, 31'd0, 64'd0, 23'd0, 7 * STRIDE, 32'd0, 1'b0);
    send_op(KIND_PROBE, 16'h0, 31'd0, 64'd0, 23'd0, '1, 32'd0, 1'b0);
    // Unmap inside a live slot but off its start, by the wrong owner, of a
    // free slot, outside the window, then the good one.
    send_op(KIND_UNMAP, 16'hFFFF, 31'd0, 64'd0, 23'd0, STRIDE + 1, 32'd0, 1'b0);
    send_op(KIND_UNMAP, 16'h0000, 31'd0, 64'd0, 23'd0, STRIDE, 32'd0, 1'b0);
    send_op(KIND_UNMAP, 16'h0000, 31'd0, 64'd0, 23'd0, 2 * STRIDE, 32'd0, 1'b0);
    send_op(KIND_UNMAP, 16'hFFFF, 31'd0, 64'd0, 23'd0, '1, 32'd0, 1'b0);
    send_op(KIND_UNMAP, 16'hFFFF, 31'd0, 64'd0, 23'd0, STRIDE, 32'd0, 1'b0);
    // Unknown kinds.
    for (k = 5; k <= 7; k++)
      send_op(3'(k), 16'h0, 31'd0, 64'd0, 23'd0, 64'd0, 32'd0, 1'b0);
    // Drain the remaining region, then drain again with nothing left.
    send_op(KIND_DRAIN, 16'h0000, 31'd0, 64'd0, 23'd0, 64'd0, 32'd0, 1'b0);
    send_op(KIND_DRAIN, 16'h0000, 31'd0, 64'd0, 23'd0, 64'd0, 32'd0, 1'b0);

    // Random part: one window setting per phase. Sender idles lightly and the
    // receiver heavily first, then the other way round, then neither.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       phase_base = {$urandom, $urandom} & ~(STRIDE - 1);
        1:       phase_base = 64'd0 - SPAN;         // window ends exactly at the top
        2:       phase_base = 64'd0 - 5 * STRIDE;   // upper slots wrap, never reached
        3:       phase_base = {$urandom, $urandom}; // unaligned base
        4:       phase_base = 64'd0;
        5:       phase_base = {$urandom, $urandom} & ~(STRIDE - 1);
        default: phase_base = '1;                   // only slot 0 start is inside
      endcase
      set_window(phase_base);
      if (ph < 2) begin
        tx_idle_pct = 20;
        rx_idle_pct <= 64;
      end else if (ph < 4) begin
        tx_idle_pct = 64;
        rx_idle_pct <= 20;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      // One owner and rare drains let the table fill completely, so a drain
      // can release every slot at once.
      owner_pool_n = (ph == 4) ? 1 : 4;
      drain_pct    = (ph == 4) ? 1 : 4;
      if (ph == 1) hold_req <= 1'b1;
      repeat (ITEMS_PER_PHASE) random_op();
    end

    req.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
